### rtl/core/bffa_pkg.sv
// Shared types and constants for the bitmap first-fit allocator.
// No dependencies; imported by the core and its checker.
`default_nettype none

package bffa_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int CMD_W     = 2;

	localparam int IN_BITS   = CMD_W + IDX_W + CNT_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + IDX_W + 2 * CNT_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC_INODE = 2'd0,
		CMD_ALLOC_BLOCK = 2'd1,
		CMD_FREE_INODE  = 2'd2,
		CMD_FREE_BLOCK  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_INODE,
		ST_SCAN_BLOCK,
		ST_CLAIM_BLOCK,
		ST_FREE_BLOCK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/core/bitmap_first_fit_allocator_core.sv
// Bitmap first-fit allocator core: inode and block occupancy maps, one-step sequencer.
// Depends on bffa_pkg.
//
// Sequence (accept to result valid): allocate inode scans position by position; allocate block
// run scans position by position, then walks the run block by block to claim it; free
// inode, zero-length or oversize block allocate go straight to the done state; free block
// run walks up from index until count blocks are freed or the map ends. One transaction in
// work at a time, the next one taken the cycle after the result loads; a finished result
// may wait on the output while the next one runs.
// Reset (arst_n low, async): both maps hold only bit 0 set, free totals NUM_SLOTS-1.
`default_nettype none

module bitmap_first_fit_allocator_core
	import bffa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // command[1:0], index[7:2], count[14:8]
	// result stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata   // ok[0], index_res[6:1], free_inodes[13:7],
	                                        // free_blocks[20:14]
);

	// request fields
	cmd_t             in_cmd;
	logic [IDX_W-1:0] in_index;
	logic [CNT_W-1:0] in_count;

	assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
	assign in_index = s_tdata[CMD_W +: IDX_W];
	assign in_count = s_tdata[CMD_W+IDX_W +: CNT_W];

	// sequencer and datapath state
	state_t               state_q, state_d;
	logic [NUM_SLOTS-1:0] inode_map_q;
	logic [NUM_SLOTS-1:0] block_map_q;
	logic [CNT_W-1:0]     inode_free_q;
	logic [CNT_W-1:0]     block_free_q;
	logic [CNT_W-1:0]     pos_q;     // scan pointer; top bit marks past the map end
	logic [CNT_W-1:0]     rem_q;     // blocks left to claim or free
	logic [CNT_W-1:0]     run_q;     // current run of free blocks
	logic [CNT_W-1:0]     cnt_q;     // requested run length
	logic                 ok_q;
	logic [IDX_W-1:0]     res_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic [IDX_W-1:0]     pos_idx;
	logic                 accept;
	logic                 out_free;
	logic                 blk_bit;
	logic                 ino_bit;
	logic [CNT_W-1:0]     run_next;
	logic                 at_last;

	assign pos_idx  = pos_q[IDX_W-1:0];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign blk_bit  = block_map_q[pos_idx];
	assign ino_bit  = inode_map_q[pos_idx];
	assign run_next = blk_bit ? '0 : run_q + 1'b1;
	assign at_last  = (pos_q == CNT_W'(NUM_SLOTS - 1));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_ALLOC_INODE: state_d = ST_SCAN_INODE;
						CMD_ALLOC_BLOCK: begin
							if (in_count == '0 || in_count > CNT_W'(NUM_SLOTS))
								state_d = ST_DONE;
							else
								state_d = ST_SCAN_BLOCK;
						end
						CMD_FREE_INODE:  state_d = ST_DONE;
						CMD_FREE_BLOCK:  state_d = ST_FREE_BLOCK;
						default:         state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN_INODE: begin
				if (!ino_bit || at_last)
					state_d = ST_DONE;
			end
			ST_SCAN_BLOCK: begin
				if (run_next == cnt_q)
					state_d = ST_CLAIM_BLOCK;
				else if (at_last)
					state_d = ST_DONE;
			end
			ST_CLAIM_BLOCK: begin
				if (rem_q == CNT_W'(1))
					state_d = ST_DONE;
			end
			ST_FREE_BLOCK: begin
				if (rem_q == '0 || pos_q >= CNT_W'(NUM_SLOTS))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// maps, totals and sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_map_q  <= NUM_SLOTS'(1);
			block_map_q  <= NUM_SLOTS'(1);
			inode_free_q <= CNT_W'(NUM_SLOTS - 1);
			block_free_q <= CNT_W'(NUM_SLOTS - 1);
			pos_q        <= '0;
			rem_q        <= '0;
			run_q        <= '0;
			cnt_q        <= '0;
			ok_q         <= 1'b0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q <= '0;
						run_q <= '0;
						cnt_q <= in_count;
						rem_q <= in_count;
						ok_q  <= 1'b1;
						res_q <= '0;
						case (in_cmd)
							CMD_ALLOC_BLOCK: begin
								// oversize run fails at once; zero-length succeeds at 0
								if (in_count > CNT_W'(NUM_SLOTS))
									ok_q <= 1'b0;
							end
							CMD_FREE_INODE: begin
								// root inode is never released
								if (in_index != '0 && inode_map_q[in_index]) begin
									inode_map_q[in_index] <= 1'b0;
									inode_free_q          <= inode_free_q + 1'b1;
								end
							end
							CMD_FREE_BLOCK: pos_q <= {1'b0, in_index};
							default: ;
						endcase
					end
				end
				ST_SCAN_INODE: begin
					if (!ino_bit) begin
						inode_map_q[pos_idx] <= 1'b1;
						inode_free_q         <= inode_free_q - 1'b1;
						res_q                <= pos_idx;
					end else if (at_last) begin
						ok_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_SCAN_BLOCK: begin
					if (run_next == cnt_q) begin
						// run ends here; claim walks back down from this position
						res_q <= IDX_W'(pos_q + 1'b1 - cnt_q);
					end else if (at_last) begin
						ok_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
						run_q <= run_next;
					end
				end
				ST_CLAIM_BLOCK: begin
					block_map_q[pos_idx] <= 1'b1;
					block_free_q         <= block_free_q - 1'b1;
					rem_q                <= rem_q - 1'b1;
					pos_q                <= pos_q - 1'b1;
				end
				ST_FREE_BLOCK: begin
					if (rem_q != '0 && pos_q < CNT_W'(NUM_SLOTS)) begin
						if (blk_bit) begin
							block_map_q[pos_idx] <= 1'b0;
							block_free_q         <= block_free_q + 1'b1;
						end
						pos_q <= pos_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register: holds a finished result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free)
			out_data_q <= OUT_W'({block_free_q, inode_free_q, res_q, ok_q});
	end

endmodule

`default_nettype wire

### rtl/core/bffa_checker.sv
// Port-level checker for the bitmap first-fit allocator core, bound into the core module.
// Depends on bffa_pkg.
`default_nettype none

module bffa_checker
	import bffa_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	logic             res_ok;
	logic [IDX_W-1:0] res_index;
	logic [CNT_W-1:0] res_ifree;
	logic [CNT_W-1:0] res_bfree;

	assign res_ok    = m_tdata[0];
	assign res_index = m_tdata[1 +: IDX_W];
	assign res_ifree = m_tdata[1+IDX_W +: CNT_W];
	assign res_bfree = m_tdata[1+IDX_W+CNT_W +: CNT_W];

	// a result held back stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// one transaction in work: no request taken in the cycle after one was taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_ok |-> res_index == '0)
		else $error("failed request reports a nonzero index");

	a_inode_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_ifree <= CNT_W'(NUM_SLOTS))
		else $error("free inode total out of range");

	a_block_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_bfree <= CNT_W'(NUM_SLOTS))
		else $error("free block total out of range");

endmodule

bind bitmap_first_fit_allocator_core bffa_checker u_bffa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
